// ----- rtl/bia_pkg.sv -----
// Shared types and codes for the bitmap identifier allocator.
package bia_pkg;

   localparam int OP_W     = 2;
   localparam int IDENT_W  = 10;
   localparam int STATUS_W = 2;

   localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
   localparam logic [OP_W-1:0] OP_CHECK = 2'd2;

   localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_NO_FREE = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_BAD_ID  = 2'd2;

   typedef struct packed {
      logic clr_write;
      logic take;
      logic alloc_start;
      logic first_eval;
      logic scan_eval;
      logic no_free;
      logic commit;
      logic div_mul;
      logic div_rem;
      logic look;
      logic load_rsp;
   } bia_cmd_type;

   typedef struct packed {
      logic hit;
      logic scan_last;
      logic clr_last;
   } bia_stat_type;

endpackage

// ----- rtl/bia_ctrl.sv -----
// Controller state machine for the bitmap identifier allocator.
module bia_ctrl
   import bia_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [OP_W-1:0]   req_operation,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  bia_stat_type      stat,
   output bia_cmd_type       cmd
);

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_FIRST  = 4'd2;
   localparam logic [3:0] S_SCAN   = 4'd3;
   localparam logic [3:0] S_COMMIT = 4'd4;
   localparam logic [3:0] S_DIV    = 4'd5;
   localparam logic [3:0] S_REM    = 4'd6;
   localparam logic [3:0] S_LOOK   = 4'd7;
   localparam logic [3:0] S_DONE   = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = (state_ff == S_IDLE);
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_write = 1'b1;
            if (stat.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               if (req_operation == OP_ALLOC) begin
                  cmd.alloc_start = 1'b1;
                  state_in        = S_FIRST;
               end else if (req_operation inside {OP_FREE, OP_CHECK}) begin
                  state_in = S_DIV;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_FIRST: begin
            cmd.first_eval = 1'b1;
            state_in       = stat.hit ? S_COMMIT : S_SCAN;
         end
         S_SCAN: begin
            cmd.scan_eval = 1'b1;
            if (stat.hit) begin
               state_in = S_COMMIT;
            end else if (stat.scan_last) begin
               cmd.no_free = 1'b1;
               state_in    = S_DONE;
            end
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = S_DONE;
         end
         S_DIV: begin
            cmd.div_mul = 1'b1;
            state_in    = S_REM;
         end
         S_REM: begin
            cmd.div_rem = 1'b1;
            state_in    = S_LOOK;
         end
         S_LOOK: begin
            cmd.look = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_write_excl: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clr_write, cmd.commit, cmd.look}))
      else $error("bitmap write sources overlap");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwrites a pending beat");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result raised outside done state");

   a_scan_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && !stat.hit && stat.scan_last) |=> state_ff == S_DONE)
      else $error("scan ran past the last word");

endmodule

// ----- rtl/bia_dp.sv -----
// Datapath of the bitmap identifier allocator: bitmap memory, search and result registers.
module bia_dp
   import bia_pkg::*;
#(
   parameter int NUM_IDS   = 1024,
   parameter int WORD_BITS = 32
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [OP_W-1:0]       req_operation,
   input  logic [IDENT_W-1:0]    req_ident,
   input  bia_cmd_type           cmd,
   output bia_stat_type          stat,
   output logic [IDENT_W-1:0]    rsp_result_ident,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic                  rsp_in_use
);

   localparam int ID_WORDS  = (NUM_IDS - 1) / WORD_BITS + 1;
   localparam int ID_TOTAL  = ID_WORDS * WORD_BITS;
   localparam int WA        = (ID_WORDS > 1) ? $clog2(ID_WORDS) : 1;
   localparam int BA        = $clog2(WORD_BITS);
   localparam int DIV_SHIFT = IDENT_W + BA;
   localparam int DIV_MULT  = (2 ** DIV_SHIFT + WORD_BITS - 1) / WORD_BITS;
   localparam int PW        = DIV_SHIFT + IDENT_W;

   logic [WORD_BITS-1:0] use_bitmap_ff [ID_WORDS];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic [WA-1:0]        rd_addr;
   logic                 wr_en;
   logic [WA-1:0]        wr_addr;
   logic [WORD_BITS-1:0] wr_data;

   logic [WA-1:0]        clr_cnt_ff;
   logic [WA-1:0]        last_word_ff;
   logic [BA-1:0]        last_bit_ff;
   logic [WA-1:0]        scan_word_ff;
   logic [WA-1:0]        scan_cnt_ff;
   logic [BA-1:0]        start_bit_ff;
   logic [WA-1:0]        found_word_ff;
   logic [WORD_BITS-1:0] found_data_ff;
   logic [WORD_BITS-1:0] found_free_ff;
   logic [OP_W-1:0]      op_ff;
   logic [IDENT_W-1:0]   ident_ff;
   logic [IDENT_W-1:0]   quot_ff;
   logic [BA-1:0]        rem_ff;
   logic [WA-1:0]        look_word_ff;
   logic                 id_ok_ff;
   logic [IDENT_W-1:0]   res_ident_ff;
   logic [STATUS_W-1:0]  res_status_ff;
   logic                 res_in_use_ff;
   logic [IDENT_W-1:0]   rsp_ident_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic                 rsp_in_use_ff;

   logic [WA-1:0]        start_word;
   logic [BA-1:0]        start_bit;
   logic [WA-1:0]        scan_next;
   logic [WORD_BITS-1:0] low_mask;
   logic [WORD_BITS-1:0] free_bits;
   logic                 hit;
   logic [BA-1:0]        low_bit;
   logic [WORD_BITS-1:0] low_onehot;
   logic [31:0]          rid_full;
   logic [PW-1:0]        prod;
   logic [31:0]          quot_times;
   logic [IDENT_W-1:0]   rem_full;
   logic [WA+IDENT_W-1:0] quot_ext;
   logic [WA-1:0]        quot_addr;
   logic                 id_ok;
   logic [WORD_BITS-1:0] rem_onehot;
   logic                 look_used;

   // next-fit start point, one past the last identifier, wrapping to 1
   always_comb begin
      if (last_bit_ff == BA'(WORD_BITS - 1)) begin
         if (last_word_ff == WA'(ID_WORDS - 1)) begin
            start_word = '0;
            start_bit  = BA'(1);
         end else begin
            start_word = last_word_ff + 1'b1;
            start_bit  = '0;
         end
      end else begin
         start_word = last_word_ff;
         start_bit  = last_bit_ff + 1'b1;
      end
   end

   assign scan_next = (scan_word_ff == WA'(ID_WORDS - 1)) ? '0 : scan_word_ff + 1'b1;
   assign low_mask  = cmd.first_eval ? ~({WORD_BITS{1'b1}} << start_bit_ff) : '0;
   assign free_bits = ~(rd_data_ff | low_mask);
   assign hit       = |free_bits;

   always_comb begin
      low_bit = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (found_free_ff[i]) begin
            low_bit = BA'(i);
         end
      end
   end

   assign low_onehot = WORD_BITS'(1) << low_bit;
   assign rid_full   = 32'(found_word_ff) * 32'(WORD_BITS) + 32'(low_bit);

   // ident / WORD_BITS by reciprocal multiply, exact over the ident range
   assign prod       = PW'(ident_ff) * PW'(DIV_MULT);
   assign quot_times = 32'(quot_ff) * 32'(WORD_BITS);
   assign rem_full   = ident_ff - quot_times[IDENT_W-1:0];
   assign quot_ext   = (WA + IDENT_W)'(quot_ff);
   assign quot_addr  = quot_ext[WA-1:0];
   assign id_ok      = (ident_ff != '0) && (32'(ident_ff) < 32'(ID_TOTAL));
   assign rem_onehot = WORD_BITS'(1) << rem_ff;
   assign look_used  = id_ok_ff && rd_data_ff[rem_ff];

   always_comb begin
      if (cmd.alloc_start) begin
         rd_addr = start_word;
      end else if (cmd.div_rem) begin
         rd_addr = quot_addr;
      end else begin
         rd_addr = scan_next;
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = clr_cnt_ff;
      wr_data = '0;
      if (cmd.clr_write) begin
         wr_en   = 1'b1;
         wr_data = (clr_cnt_ff == '0) ? WORD_BITS'(1) : '0;
      end else if (cmd.commit) begin
         wr_en   = 1'b1;
         wr_addr = found_word_ff;
         wr_data = found_data_ff | low_onehot;
      end else if (cmd.look && op_ff == OP_FREE && look_used) begin
         wr_en   = 1'b1;
         wr_addr = look_word_ff;
         wr_data = rd_data_ff & ~rem_onehot;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         use_bitmap_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= use_bitmap_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff   <= '0;
         last_word_ff <= '0;
         last_bit_ff  <= '0;
      end else begin
         if (cmd.clr_write) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
         end
         if (cmd.commit) begin
            last_word_ff <= found_word_ff;
            last_bit_ff  <= low_bit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         op_ff         <= req_operation;
         ident_ff      <= req_ident;
         res_ident_ff  <= '0;
         res_in_use_ff <= 1'b0;
         res_status_ff <= (req_operation inside {OP_ALLOC, OP_FREE, OP_CHECK}) ?
                          STAT_OK : STAT_BAD_ID;
      end
      if (cmd.alloc_start) begin
         scan_word_ff <= start_word;
         start_bit_ff <= start_bit;
      end
      if (cmd.first_eval || cmd.scan_eval) begin
         if (hit) begin
            found_word_ff <= scan_word_ff;
            found_data_ff <= rd_data_ff;
            found_free_ff <= free_bits;
         end else begin
            scan_word_ff <= scan_next;
         end
      end
      if (cmd.first_eval) begin
         scan_cnt_ff <= '0;
      end else if (cmd.scan_eval && !hit) begin
         scan_cnt_ff <= scan_cnt_ff + 1'b1;
      end
      if (cmd.no_free) begin
         res_status_ff <= STAT_NO_FREE;
      end
      if (cmd.commit) begin
         res_ident_ff <= rid_full[IDENT_W-1:0];
      end
      if (cmd.div_mul) begin
         quot_ff <= prod[DIV_SHIFT +: IDENT_W];
      end
      if (cmd.div_rem) begin
         rem_ff       <= rem_full[BA-1:0];
         look_word_ff <= quot_addr;
         id_ok_ff     <= id_ok;
      end
      if (cmd.look) begin
         if (op_ff == OP_CHECK) begin
            res_in_use_ff <= look_used;
         end else begin
            res_status_ff <= look_used ? STAT_OK : STAT_BAD_ID;
         end
      end
      if (cmd.load_rsp) begin
         rsp_ident_ff  <= res_ident_ff;
         rsp_status_ff <= res_status_ff;
         rsp_in_use_ff <= res_in_use_ff;
      end
   end

   assign stat.hit       = hit;
   assign stat.scan_last = (scan_cnt_ff == WA'(ID_WORDS - 1));
   assign stat.clr_last  = (clr_cnt_ff == WA'(ID_WORDS - 1));

   assign rsp_result_ident = rsp_ident_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_in_use       = rsp_in_use_ff;

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> |found_free_ff)
      else $error("commit without a free bit");

   a_commit_last: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> (last_word_ff == $past(found_word_ff)))
      else $error("last identifier not updated on commit");

endmodule

// ----- rtl/bitmap_id_allocator.sv -----
// Top level of the next-fit bitmap identifier allocator.
//
//   channel | direction | ports
//   req     | in        | req_valid, req_ready, req_operation, req_ident
//   rsp     | out       | rsp_valid, rsp_ready, rsp_result_ident, rsp_status, rsp_in_use
//
// Allocate: the start word alone is read and evaluated when it has a free bit at or above the start point; otherwise
//   the bitmap is scanned one word per cycle through a single memory read port.
// Free and check: reciprocal divide, remainder, word read. A bad opcode goes straight to the result.
// After reset a clearing pass writes all ID_WORDS words, one per cycle, with req_ready low.
// One finished result is held in the output register; the next is held until rsp_ready.
module bitmap_id_allocator
   import bia_pkg::*;
#(
   parameter int NUM_IDS   = 1024,
   parameter int WORD_BITS = 32
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [OP_W-1:0]       req_operation,
   input  logic [IDENT_W-1:0]    req_ident,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [IDENT_W-1:0]    rsp_result_ident,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic                  rsp_in_use
);

   bia_cmd_type  cmd;
   bia_stat_type stat;

   bia_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_ready     (req_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .stat          (stat),
      .cmd           (cmd)
   );

   bia_dp #(
      .NUM_IDS   (NUM_IDS),
      .WORD_BITS (WORD_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_operation    (req_operation),
      .req_ident        (req_ident),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_result_ident (rsp_result_ident),
      .rsp_status       (rsp_status),
      .rsp_in_use       (rsp_in_use)
   );

endmodule
